@@ hw/rtl/aes256ke_pkg.sv @@
// Shared types, constants and lookup tables for the AES-256 key expansion core.
`default_nettype none
package aes256ke_pkg;

  localparam int unsigned KEY_WORDS   = 8;
  localparam int unsigned TOTAL_WORDS = 60;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned IN_TDATA_W  = KEY_WORDS * WORD_W;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL_WORDS - 1);

  // Step positions within an eight-word group that select the transform.
  localparam logic [2:0] POS_ROT_SUB = 3'd0;
  localparam logic [2:0] POS_SUB     = 3'd4;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant for the group number; groups past the seventh add nothing.
  function automatic logic [7:0] rcon_byte(input logic [2:0] grp);
    logic [7:0] r;
    unique case (grp)
      3'd0:    r = 8'h01;
      3'd1:    r = 8'h02;
      3'd2:    r = 8'h04;
      3'd3:    r = 8'h08;
      3'd4:    r = 8'h10;
      3'd5:    r = 8'h20;
      3'd6:    r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aes256ke_cell.sv @@
// One word cell of the schedule window: loads a key word or takes its neighbour's word.
`default_nettype none
module aes256ke_cell (
  input  wire logic                        clk,
  input  wire aes256ke_pkg::cell_ctrl_t    ctrl,
  input  wire logic [31:0]                 load_word,
  input  wire logic [31:0]                 shift_in,
  output logic      [31:0]                 word_o
);
  import aes256ke_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.load) begin
      word_nxt = load_word;
    end else if (ctrl.shift) begin
      word_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule
`default_nettype wire

@@ hw/rtl/aes256ke_subword.sv @@
// SubWord unit: four parallel S-box lookups on one 32-bit word.
`default_nettype none
module aes256ke_subword (
  input  wire logic [31:0] word_i,
  output logic      [31:0] word_o
);
  import aes256ke_pkg::*;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      word_o[b*8 +: 8] = SBOX[word_i[b*8 +: 8]];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/aes256_key_expansion_core.sv @@
// Top level of the AES-256 key expansion core: cell chain, shared SubWord unit and stream control.
`default_nettype none
// A request on the input carries one 256-bit key and yields 60 expanded round-key words,
// one result per cycle while the output is ready. A key occupies the block from its input
// request until its last result word is accepted. The schedule runs through a row of eight
// word cells that shift by one word per result; the word entering the far end is built from
// the two ends of the row through one SubWord unit, and that single step per cycle sets the
// pace. A new key is taken in the cycle after the last word of the previous key has been
// accepted. The word on the output comes straight from the first cell.
module aes256_key_expansion_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // key_word_0 [31:0], key_word_1 [63:32], ... key_word_7 [255:224]
  input  wire logic [255:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // word_index [5:0], round_key_word [37:6], zero [39:38]
  output logic [39:0]       out_tdata,
  output logic              out_tlast
);
  import aes256ke_pkg::*;

  logic                busy_r;
  logic                busy_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    idx_nxt;
  logic                in_req;
  logic                out_req;
  cell_ctrl_t          ctrl;
  logic [WORD_W-1:0]   cell_word [KEY_WORDS];
  logic [WORD_W-1:0]   sub_in;
  logic [WORD_W-1:0]   sub_out;
  logic [WORD_W-1:0]   xform;
  logic [WORD_W-1:0]   new_word;
  logic [2:0]          pos;

  assign in_tready = !busy_r;
  assign in_req    = in_tvalid && in_tready;
  assign out_req   = out_tvalid && out_tready;

  assign ctrl.load  = in_req;
  assign ctrl.shift = out_req;

  // The window holds words idx..idx+7; the word idx+8 has the same position in its group as idx.
  assign pos = idx_r[2:0];

  always_comb begin
    if (pos == POS_ROT_SUB) begin
      sub_in = {cell_word[KEY_WORDS-1][23:0], cell_word[KEY_WORDS-1][31:24]};
    end else begin
      sub_in = cell_word[KEY_WORDS-1];
    end
  end

  aes256ke_subword u_subword (
    .word_i (sub_in),
    .word_o (sub_out)
  );

  always_comb begin
    if (pos == POS_ROT_SUB) begin
      xform = sub_out ^ {rcon_byte(idx_r[5:3]), 24'h000000};
    end else if (pos == POS_SUB) begin
      xform = sub_out;
    end else begin
      xform = cell_word[KEY_WORDS-1];
    end
  end

  assign new_word = cell_word[0] ^ xform;

  for (genvar k = 0; k < KEY_WORDS; k++) begin : g_cell
    logic [WORD_W-1:0] shift_src;
    if (k == KEY_WORDS - 1) begin : g_end
      assign shift_src = new_word;
    end else begin : g_mid
      assign shift_src = cell_word[k+1];
    end
    aes256ke_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_word (in_tdata[k*WORD_W +: WORD_W]),
      .shift_in  (shift_src),
      .word_o    (cell_word[k])
    );
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (in_req) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (out_req) begin
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {2'b00, cell_word[0], idx_r};
  assign out_tlast  = (idx_r == LAST_IDX);

  a_last_ends_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_req && out_tlast |=> !out_tvalid)
    else $error("output still valid after last word of a key");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_req && !out_tlast |=> out_tvalid && (out_tdata[5:0] == $past(out_tdata[5:0]) + 6'd1))
    else $error("word index did not advance by one");

  a_key_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_req |=> out_tvalid && (out_tdata[5:0] == 6'd0) && !in_tready)
    else $error("new key did not start at word zero");

endmodule
`default_nettype wire
